### src/pstp_pkg.sv
// Shared widths, codes and types of the pivot swap permutation block.
package pstp_pkg;

  // Field widths of the request and response channels.
  localparam int unsigned ROW_W    = 11;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned RIDX_W   = 10;
  localparam int unsigned STATUS_W = 2;

  // Width of the generation tag kept beside each table entry.
  localparam int unsigned EPOCH_W = 8;

  // Default table depth and the reset value of the row count register.
  localparam int unsigned   MAX_ROWS_DEF  = 1024;
  localparam logic [10:0]   ROW_COUNT_RST = 11'd1024;

  // Request operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_APPLY = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_PIVOT = 2'd1,
    ST_TOO_MANY  = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  // One response item.
  typedef struct packed {
    status_e          status;
    logic [ROW_W-1:0] value;
  } result_t;

endpackage

### src/pstp_if.sv
// Valid/ready channel interfaces for requests and responses.
interface pstp_req_if;
  logic                          valid;
  logic                          ready;
  logic [pstp_pkg::OP_W-1:0]     operation;
  logic [pstp_pkg::ROW_W-1:0]    pivot_row;
  logic [pstp_pkg::RIDX_W-1:0]   read_index;

  modport source (output valid, output operation, output pivot_row, output read_index,
                  input ready);
  modport sink (input valid, input operation, input pivot_row, input read_index,
                output ready);
endinterface

interface pstp_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [pstp_pkg::ROW_W-1:0]      row_value;
  logic [pstp_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output row_value, output status, input ready);
  modport sink (input valid, input row_value, input status, output ready);
endinterface

### src/pivot_swaps_to_permutation.sv
// Top level: turns a sequence of LU pivot swaps into a row permutation table.
//
// Requests arrive on req_i (operation, pivot_row, read_index) and each one
// gives exactly one response on rsp_o (row_value, status), in order. A start
// resets the table to the identity, an apply swaps entry pivot_row-1 with the
// entry at the step counter and advances it, and a read returns the one-based
// row at read_index. The row count register is written through cfg_we_i.
// A request is taken only while the sequencer is idle. A start, an unused code
// or a rejected apply or read goes from acceptance straight to the respond state
// S_EMIT, a read passes the read state S_READ first, and an accepted swap passes
// the write states S_SWAP_A and S_SWAP_B, because both swapped entries go back
// through the single write port of the table RAM in turn. The response is registered.
// After reset the table RAM is swept once, entry by entry, before the first
// request is taken. Each entry carries a generation tag, so a start costs no
// sweep except on every (2**EPOCH_W - 1)-th start, when the tags wrap and the
// same sweep runs before that start's response.
// When the receiver stalls, a finished response waits in the output register
// while the next request is accepted and worked on; that request then holds
// its response until the output register is free.
module pivot_swaps_to_permutation #(
  parameter int unsigned MAX_ROWS = pstp_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pstp_pkg::ROW_W-1:0]  cfg_wdata_i,
  pstp_req_if.sink                    req_i,
  pstp_rsp_if.source                  rsp_o
);

  localparam int unsigned IW     = $clog2(MAX_ROWS);
  localparam int unsigned ROW_W  = pstp_pkg::ROW_W;
  localparam int unsigned EW     = pstp_pkg::EPOCH_W;
  localparam int unsigned WORD_W = EW + ROW_W;
  localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_ROWS - 1);
  localparam logic [EW-1:0] EPOCH_TOP = {EW{1'b1}};
  localparam logic [EW-1:0] EPOCH_ONE = EW'(1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_SWAP_A = 6'b001000,
    S_SWAP_B = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [ROW_W-1:0]      row_count_q;
  logic [ROW_W-1:0]      swap_step_q, swap_step_d;
  logic [EW-1:0]         epoch_q, epoch_d;
  logic [IW-1:0]         clr_cnt_q, clr_cnt_d;
  logic                  clr_emit_q, clr_emit_d;
  logic                  out_valid_q, out_valid_d;
  logic [IW-1:0]         a_q, a_d;
  logic [IW-1:0]         b_q, b_d;
  logic [ROW_W-1:0]      hold_q, hold_d;
  pstp_pkg::result_t     pend_q, pend_d;
  pstp_pkg::result_t     out_q, out_d;

  logic [ROW_W-1:0]      rows_used;
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [IW-1:0]         ram_raddr_a;
  logic [IW-1:0]         ram_raddr_b;
  logic [WORD_W-1:0]     ram_rdata_a;
  logic [WORD_W-1:0]     ram_rdata_b;

  // An entry whose tag is from an older generation reads as its identity row.
  function automatic logic [ROW_W-1:0] resolve(input logic [WORD_W-1:0] word,
                                               input logic [IW-1:0]     idx,
                                               input logic [EW-1:0]     epoch);
    logic [ROW_W-1:0] ident;
    ident = ROW_W'(idx) + ROW_W'(1);
    return (word[WORD_W-1:ROW_W] == epoch) ? word[ROW_W-1:0] : ident;
  endfunction

  // Effective row count, saturated to the table depth.
  assign rows_used = (32'(row_count_q) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : row_count_q;

  // Table entries with their generation tags.
  pstp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ROWS)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (ram_rdata_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_b_o (ram_rdata_b)
  );

  // Read addresses come straight from the request and the step counter.
  assign ram_raddr_a = (req_i.operation == pstp_pkg::OP_READ) ?
                       IW'(req_i.read_index) : IW'(req_i.pivot_row - ROW_W'(1));
  assign ram_raddr_b = IW'(swap_step_q);

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.row_value = out_q.value;
  assign rsp_o.status    = out_q.status;

  // Sequencer: decode, read, modify, write back, respond.
  always_comb begin
    state_d     = state_q;
    swap_step_d = swap_step_q;
    epoch_d     = epoch_q;
    clr_cnt_d   = clr_cnt_q;
    clr_emit_d  = clr_emit_q;
    out_valid_d = out_valid_q;
    a_d         = a_q;
    b_d         = b_q;
    hold_d      = hold_q;
    pend_d      = pend_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = a_q;
    ram_wdata   = '0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + IW'(1);
        if (clr_cnt_q == LAST_IDX) begin
          clr_cnt_d  = '0;
          clr_emit_d = 1'b0;
          state_d    = clr_emit_q ? S_EMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          a_d    = ram_raddr_a;
          b_d    = ram_raddr_b;
          pend_d = '{status: pstp_pkg::ST_OK, value: '0};
          state_d = S_EMIT;
          case (req_i.operation)
            pstp_pkg::OP_START: begin
              swap_step_d = '0;
              if (epoch_q == EPOCH_TOP) begin
                epoch_d    = EPOCH_ONE;
                clr_emit_d = 1'b1;
                state_d    = S_CLEAR;
              end else begin
                epoch_d = epoch_q + EPOCH_ONE;
              end
            end
            pstp_pkg::OP_APPLY: begin
              if (req_i.pivot_row == '0 || req_i.pivot_row > rows_used) begin
                pend_d.status = pstp_pkg::ST_BAD_PIVOT;
              end else if (swap_step_q >= rows_used) begin
                pend_d.status = pstp_pkg::ST_TOO_MANY;
              end else begin
                state_d = S_SWAP_A;
              end
            end
            pstp_pkg::OP_READ: begin
              if ({1'b0, req_i.read_index} >= rows_used) begin
                pend_d.status = pstp_pkg::ST_BAD_INDEX;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_READ: begin
        pend_d.value = resolve(ram_rdata_a, a_q, epoch_q);
        state_d      = S_EMIT;
      end
      S_SWAP_A: begin
        // Entry at the pivot takes the step entry; the pivot value is held.
        ram_we    = 1'b1;
        ram_waddr = a_q;
        ram_wdata = {epoch_q, resolve(ram_rdata_b, b_q, epoch_q)};
        hold_d    = resolve(ram_rdata_a, a_q, epoch_q);
        state_d   = S_SWAP_B;
      end
      S_SWAP_B: begin
        ram_we      = 1'b1;
        ram_waddr   = b_q;
        ram_wdata   = {epoch_q, hold_q};
        swap_step_d = swap_step_q + ROW_W'(1);
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      row_count_q <= pstp_pkg::ROW_COUNT_RST;
      swap_step_q <= '0;
      epoch_q     <= EPOCH_ONE;
      clr_cnt_q   <= '0;
      clr_emit_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      swap_step_q <= swap_step_d;
      epoch_q     <= epoch_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_emit_q  <= clr_emit_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        row_count_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    hold_q <= hold_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // The second write of a swap always follows the first.
  a_swap_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWAP_A |=> state_q == S_SWAP_B)
    else $error("swap write-back did not complete in order");

  // The step counter advances by exactly one per completed swap.
  a_step_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWAP_B |=> swap_step_q == $past(swap_step_q) + ROW_W'(1))
    else $error("step counter did not advance after a swap");

  // Generation zero marks swept entries and is never current.
  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("current generation tag is zero");

  // A new response is loaded only from the respond state.
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_EMIT)
    else $error("response appeared outside the respond state");

endmodule

### src/pstp_ram.sv
// Generic RAM with one write port and two registered read ports.
module pstp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write and registered reads; a read of the written address returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### tb/sv/pivot_swaps_to_permutation_test.sv
// Self-checking testbench of the pivot swap permutation block with a built-in predictor.
`timescale 1ns / 100ps

module pivot_swaps_to_permutation_test;
  import pstp_pkg::*;

  localparam int unsigned TABLE_ROWS    = 1024;
  localparam int unsigned ITEMS_TARGET  = 925;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ROW_W-1:0] cfg_wdata;

  pstp_req_if req_bus ();
  pstp_rsp_if rsp_bus ();

  pivot_swaps_to_permutation #(
    .MAX_ROWS(TABLE_ROWS)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  // Predictor state: row count register, permutation table, valid bits, step counter.
  logic [ROW_W-1:0] row_count_q;
  logic [ROW_W-1:0] perm_rows [TABLE_ROWS];
  bit               row_written [TABLE_ROWS];
  logic [ROW_W-1:0] step_k;

  // Answers predicted for accepted requests, oldest first.
  result_t pending_answers[$];

  int unsigned items_sent;
  int unsigned answers_checked;
  int unsigned mismatch_count;
  bit          idle_on;

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rows in use: the register saturated to the table depth.
  function automatic int unsigned active_rows();
    return (row_count_q > TABLE_ROWS) ? TABLE_ROWS : int'(row_count_q);
  endfunction

  // An entry never written since the last start reads as its index plus one.
  function automatic logic [ROW_W-1:0] table_entry(input logic [RIDX_W-1:0] idx);
    return row_written[idx] ? perm_rows[idx] : ROW_W'({1'b0, idx} + 11'd1);
  endfunction

  // Works out the answer to one request and updates the predicted table.
  function automatic result_t swap_table_answer(input logic [OP_W-1:0] op,
                                                input logic [ROW_W-1:0] piv,
                                                input logic [RIDX_W-1:0] ridx);
    result_t          ans;
    int unsigned      m;
    logic [ROW_W-1:0] slot;
    logic [ROW_W-1:0] va;
    logic [ROW_W-1:0] vb;
    ans.value  = '0;
    ans.status = ST_OK;
    m = active_rows();
    case (op)
      OP_START: begin
        for (int i = 0; i < TABLE_ROWS; i++) row_written[i] = 1'b0;
        step_k = '0;
      end
      OP_APPLY: begin
        if (piv == 0 || piv > m) begin
          ans.status = ST_BAD_PIVOT;
        end else if (step_k >= m) begin
          ans.status = ST_TOO_MANY;
        end else begin
          slot = piv - 11'd1;
          va = table_entry(slot[RIDX_W-1:0]);
          vb = table_entry(step_k[RIDX_W-1:0]);
          perm_rows[slot[RIDX_W-1:0]]     = vb;
          row_written[slot[RIDX_W-1:0]]   = 1'b1;
          perm_rows[step_k[RIDX_W-1:0]]   = va;
          row_written[step_k[RIDX_W-1:0]] = 1'b1;
          step_k = step_k + 11'd1;
        end
      end
      OP_READ: begin
        if (ridx >= m) ans.status = ST_BAD_INDEX;
        else ans.value = table_entry(ridx);
      end
      default: begin
        // The unused code changes nothing and answers zero.
      end
    endcase
    return ans;
  endfunction

  // Idle stretch length: mostly short, now and then long.
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sends one request, records its predicted answer at acceptance, then maybe idles.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] piv,
                              input logic [RIDX_W-1:0] ridx);
    int unsigned gap;
    req_bus.valid      <= 1'b1;
    req_bus.operation  <= op;
    req_bus.pivot_row  <= piv;
    req_bus.read_index <= ridx;
    do @(posedge clk); while (!req_bus.ready);
    pending_answers.push_back(swap_table_answer(op, piv, ridx));
    items_sent++;
    gap = (idle_on && $urandom_range(0, 99) < 35) ? idle_cycles() : 0;
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds off requests until every predicted answer has come back.
  task automatic wait_answers_done();
    req_bus.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the row count register once the block is idle.
  task automatic load_row_count(input logic [ROW_W-1:0] rows);
    wait_answers_done();
    cfg_we    <= 1'b1;
    cfg_wdata <= rows;
    @(posedge clk);
    row_count_q = rows;
    cfg_we <= 1'b0;
  endtask

  // Receiver side: random stalls on the response channel.
  int unsigned stall_left;
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      rsp_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      stall_left = idle_cycles() - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // Response checker: each accepted response against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected response row_value %0d status %0d", $time,
                   rsp_bus.row_value, rsp_bus.status);
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (rsp_bus.row_value !== want.value || rsp_bus.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: response %0d got row_value %0d status %0d, expected %0d status %0d",
                     $time, answers_checked, rsp_bus.row_value, rsp_bus.status,
                     want.value, want.status);
        end
      end
    end
  end

  // Reset values, field extremes and the first swaps on a full-size table.
  task automatic test_full_table_swaps();
    send_request(OP_READ, 11'd0, 10'd0);
    send_request(OP_READ, 11'd2047, 10'd1023);
    send_request(OP_APPLY, 11'd0, 10'd0);
    send_request(OP_APPLY, 11'd2047, 10'd1023);
    send_request(OP_APPLY, 11'd1025, 10'd0);
    send_request(OP_APPLY, 11'd1024, 10'd0);
    send_request(OP_APPLY, 11'd1, 10'd1023);
    send_request(OP_READ, 11'd0, 10'd0);
    send_request(OP_READ, 11'd0, 10'd1);
    send_request(OP_READ, 11'd0, 10'd1023);
    send_request(OP_UNUSED, 11'd2047, 10'd1023);
    send_request(OP_START, 11'd2047, 10'd1023);
    send_request(OP_READ, 11'd0, 10'd1);
  endtask

  // Row count at its limits and changed in the middle of a sequence.
  task automatic test_row_count_limits();
    load_row_count(11'd1);
    send_request(OP_APPLY, 11'd1, 10'd0);
    send_request(OP_APPLY, 11'd1, 10'd0);
    send_request(OP_APPLY, 11'd2, 10'd0);
    send_request(OP_READ, 11'd0, 10'd0);
    send_request(OP_READ, 11'd0, 10'd1);
    load_row_count(11'd0);
    send_request(OP_APPLY, 11'd1, 10'd0);
    send_request(OP_READ, 11'd0, 10'd0);
    send_request(OP_START, 11'd0, 10'd0);
    load_row_count(11'd2047);
    send_request(OP_READ, 11'd0, 10'd1023);
    send_request(OP_APPLY, 11'd1024, 10'd0);
    load_row_count(11'd3);
    send_request(OP_READ, 11'd0, 10'd1023);
    load_row_count(11'd1024);
    send_request(OP_READ, 11'd0, 10'd1023);
  endtask

  // Many starts in a row so that the entry generation tags wrap.
  task automatic test_repeated_starts();
    idle_on = 1'b0;
    for (int i = 0; i < 260; i++) begin
      send_request(OP_START, ROW_W'($urandom), RIDX_W'($urandom));
      if (i % 8 == 7) begin
        send_request(OP_APPLY, ROW_W'($urandom_range(1, TABLE_ROWS)), RIDX_W'($urandom));
        send_request(OP_READ, ROW_W'($urandom), RIDX_W'($urandom));
      end
    end
    idle_on = 1'b1;
  endtask

  // One start, mostly well-formed pivots with some noise, then reads of the result.
  task automatic run_swap_sequence(input int unsigned m);
    int unsigned n_apply;
    int unsigned n_read;
    int unsigned k;
    int unsigned r;
    logic [ROW_W-1:0] piv;
    logic [RIDX_W-1:0] ridx;
    send_request(OP_START, ROW_W'($urandom), RIDX_W'($urandom));
    n_apply = (m <= 16) ? m + $urandom_range(0, 2) : $urandom_range(6, 30);
    for (int i = 0; i < n_apply; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80 && m != 0) begin
        k = step_k;
        piv = (k < m) ? ROW_W'($urandom_range(k + 1, m)) : ROW_W'($urandom_range(1, m));
        send_request(OP_APPLY, piv, RIDX_W'($urandom));
      end else if (r < 90) begin
        send_request(OP_APPLY, ROW_W'($urandom), RIDX_W'($urandom));
      end else if (r < 96) begin
        send_request(OP_READ, ROW_W'($urandom), RIDX_W'($urandom));
      end else begin
        send_request(OP_UNUSED, ROW_W'($urandom), RIDX_W'($urandom));
      end
    end
    n_read = (m <= 16) ? m + 2 : $urandom_range(8, 20);
    for (int i = 0; i < n_read; i++) begin
      if (m != 0 && $urandom_range(0, 99) < 85) ridx = RIDX_W'($urandom_range(0, m - 1));
      else ridx = RIDX_W'($urandom);
      send_request(OP_READ, ROW_W'($urandom), ridx);
    end
  endtask

  // Random phases over a spread of row counts, small ones most often.
  task automatic test_random_sequences();
    int unsigned r;
    logic [ROW_W-1:0] rows;
    while (items_sent < ITEMS_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 5) rows = 11'd0;
      else if (r < 10) rows = 11'd1;
      else if (r < 15) rows = 11'd2;
      else if (r < 19) rows = 11'd2047;
      else if (r < 23) rows = 11'd1024;
      else if (r < 27) rows = 11'd1023;
      else if (r < 75) rows = ROW_W'($urandom_range(3, 16));
      else rows = ROW_W'($urandom_range(17, 200));
      idle_on = ($urandom_range(0, 99) < 80);
      load_row_count(rows);
      repeat ($urandom_range(1, 3)) run_swap_sequence(active_rows());
    end
  endtask

  // Main sequence.
  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_bus.valid      = 1'b0;
    req_bus.operation  = OP_START;
    req_bus.pivot_row  = '0;
    req_bus.read_index = '0;
    rsp_bus.ready      = 1'b0;
    stall_left         = 0;
    idle_on            = 1'b1;
    items_sent         = 0;
    answers_checked    = 0;
    mismatch_count     = 0;
    row_count_q        = ROW_COUNT_RST;
    step_k             = '0;
    for (int i = 0; i < TABLE_ROWS; i++) begin
      row_written[i] = 1'b0;
      perm_rows[i]   = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_table_swaps();
    test_row_count_limits();
    test_repeated_starts();
    test_random_sequences();
    wait_answers_done();

    $display("Sent %0d requests and checked %0d responses over row counts 0 to 2047,",
             items_sent, answers_checked);
    $display("with restarts, swap overflow, bad pivots and bad read indices.");
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("pivot_swaps_to_permutation: match");
    end else begin
      $display("pivot_swaps_to_permutation: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #6_000_000;
    $display("pivot_swaps_to_permutation: mismatch");
    $finish;
  end

endmodule

### sim.f
src/pstp_pkg.sv
src/pstp_if.sv
src/pstp_ram.sv
src/pivot_swaps_to_permutation.sv
tb/sv/pivot_swaps_to_permutation_test.sv
